[hw/rtl/nofm_pkg.sv]
// ----------------------------------------------------------------------------
// nofm_pkg: shared definitions for the n-of-m occurrence filter
// Widths, operation and register codes, controller states and the command
// and status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nofm_pkg;

    // Field widths
    localparam int ID_W       = 12;
    localparam int CNT_W      = 9;
    localparam int N_W        = 8;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    // Default size of the counter store
    localparam int NUM_IDS_DEF = 4096;

    // Register reset values
    localparam logic [N_W-1:0] N_REQUIRED_RST = 8'd1;
    localparam logic           EXACT_MODE_RST = 1'b0;

    // Operation codes carried in s_tuser
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_READOUT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_N_REQUIRED = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXACT_MODE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } ctrl_state_t;

    typedef struct packed {
        logic clear_wr;  // write zero at the sweep address and advance it
        logic accept;    // take the input transfer and start the counter read
        logic commit;    // write the counter back and load any result
    } nofm_cmd_t;

    typedef struct packed {
        logic clear_last;  // the sweep is at the final entry
        logic is_readout;  // the item in hand is a readout
        logic out_free;    // the output register can take a result now
    } nofm_stat_t;

endpackage

[hw/rtl/n_of_m_occurrence_filter_unit.sv]
// ----------------------------------------------------------------------------
// n_of_m_occurrence_filter_unit: n-of-m occurrence filter top level
// Counts how many id sets each record id occurs in and reports, on readout,
// whether the id meets the at-least-n or exactly-n condition.
// ----------------------------------------------------------------------------
// Use of the block:
// The input stream carries one item per transfer. s_tuser is the operation:
// a load counts one occurrence of the id in s_tdata, a readout asks for the
// verdict on that id and clears its counter. Each readout produces exactly
// one transfer on the result stream, carrying the id and the selected flag;
// loads produce nothing. Ids at or above NUM_IDS are ignored by loads and
// read out as not selected.
// Every item passes through an accept cycle, in which the counter store is
// read, and an update cycle, in which the counter is written back. The next
// item's read has to follow that write-back, so no new item is taken until
// the last one is written back. A readout result is loaded into the result
// register in its update cycle once that register is free, then drives m_tvalid.
// After reset the counter store is swept to zero, one entry a cycle, over all
// NUM_IDS entries; s_tready stays low meanwhile, but configuration writes are
// taken at any time. n_required resets to 1 and exact_mode to 0.
// When the receiver stalls, the held result does not block the input: a
// further item is still accepted, and only a second readout waits in its
// update cycle until the result register has been emptied.
// ----------------------------------------------------------------------------
module n_of_m_occurrence_filter_unit #(
    parameter int NUM_IDS = nofm_pkg::NUM_IDS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Configuration write port: index 0 is n_required, index 1 is exact_mode.
    input  logic                               cfg_wr_en,
    input  logic [nofm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [nofm_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [nofm_pkg::S_TDATA_W-1:0]     s_tdata,  // [11:0] record_id, rest zero
    input  logic                               s_tuser,  // [0] op

    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [nofm_pkg::M_TDATA_W-1:0]     m_tdata   // [11:0] result_id, [12] selected
);

    import nofm_pkg::*;

    nofm_cmd_t  cmd;
    nofm_stat_t stat;

    // The controller sequences each item; it sees only status from the datapath.
    nofm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the counter store, the registers and the result.
    nofm_datapath #(
        .NUM_IDS (NUM_IDS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[hw/rtl/nofm_ram.sv]
// ----------------------------------------------------------------------------
// nofm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nofm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/nofm_datapath.sv]
// ----------------------------------------------------------------------------
// nofm_datapath: counter store, configuration and result register
// Holds the item in hand, updates its counter and forms the readout result.
// ----------------------------------------------------------------------------
module nofm_datapath #(
    parameter int NUM_IDS = nofm_pkg::NUM_IDS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [nofm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [nofm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [nofm_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    input  nofm_pkg::nofm_cmd_t                 cmd,
    output nofm_pkg::nofm_stat_t                stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [nofm_pkg::M_TDATA_W-1:0]      m_tdata
);

    import nofm_pkg::*;

    localparam int ADDR_W = $clog2(NUM_IDS);

    logic [N_W-1:0]    n_reg;
    logic              exact_reg;
    logic              op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ID_W-1:0]   out_id_reg;
    logic              out_sel_reg;

    logic              in_range;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  n_ext;
    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  load_count;
    logic              sel;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [CNT_W-1:0]  ram_wr_data;

    // Configuration registers, writable at any time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg     <= N_REQUIRED_RST;
            exact_reg <= EXACT_MODE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_N_REQUIRED: n_reg     <= cfg_wdata;
                CFG_EXACT_MODE: exact_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Item in hand
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg <= s_tuser;
            id_reg <= s_tdata[ID_W-1:0];
        end
    end

    // Clearing sweep address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_wr) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign in_range   = (32'(id_reg) < NUM_IDS);
    assign n_ext      = {1'b0, n_reg};
    assign limit      = n_ext + 1'b1;
    assign load_count = (count < limit) ? CNT_W'(count + 1'b1) : count;
    assign sel        = in_range && (exact_reg ? (count == n_ext) : (count >= n_ext));

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = ADDR_W'(id_reg);
        ram_wr_data = '0;
        if (cmd.clear_wr) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
        end else if (cmd.commit && in_range) begin
            ram_wr_en   = 1'b1;
            ram_wr_data = (op_reg == OP_READOUT) ? '0 : load_count;
        end
    end

    nofm_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_IDS)
    ) u_counts (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (ADDR_W'(s_tdata[ID_W-1:0])),
        .rd_data (count)
    );

    // Result register: filled by a committed readout, drained by m_tready
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit && (op_reg == OP_READOUT)) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && (op_reg == OP_READOUT)) begin
            out_id_reg  <= id_reg;
            out_sel_reg <= sel;
        end
    end

    assign stat.clear_last = (clr_addr_reg == ADDR_W'(NUM_IDS - 1));
    assign stat.is_readout = (op_reg == OP_READOUT);
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_sel_reg, out_id_reg});

endmodule

[hw/rtl/nofm_ctrl.sv]
// ----------------------------------------------------------------------------
// nofm_ctrl: sequencing controller
// Runs the clearing sweep after reset, then takes one item at a time
// through an accept cycle and an update cycle.
// ----------------------------------------------------------------------------
module nofm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  nofm_pkg::nofm_stat_t  stat,
    output nofm_pkg::nofm_cmd_t   cmd
);

    import nofm_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.clear_wr = 1'b0;
        cmd.accept   = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // A readout waits here while the result register is still full.
                if (!stat.is_readout || stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

[bench/tb_n_of_m_occurrence_filter_unit.sv]
// ----------------------------------------------------------------------------
// tb_n_of_m_occurrence_filter_unit: self-checking bench for the n-of-m filter
// Streams load and readout items into the filter and predicts every verdict
// from a tally of occurrences per record id. It covers threshold and exact
// modes, counter saturation, n_required of zero and 255, and back-pressure
// from a stalling result receiver.
// ----------------------------------------------------------------------------
module tb_n_of_m_occurrence_filter_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import nofm_pkg::*;

    localparam int NUM_IDS          = NUM_IDS_DEF;
    // Cycles without any transfer before the run is abandoned. This covers the
    // clearing sweep after reset and the long receiver hold-offs with room.
    localparam int IDLE_LIMIT       = 20000;
    localparam int LONG_HOLD_CYCLES = 600;
    // An item is done once its update cycle has written its counter back; a margin
    // of SETTLE_CYCLES is allowed before the registers are touched or the run is closed.
    localparam int SETTLE_CYCLES    = 8;
    localparam int REPORT_LIMIT     = 10;

    typedef struct packed {
        logic            op;
        logic [ID_W-1:0] id;
    } filter_item_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            selected;
    } verdict_t;

    // How the result receiver paces itself within one segment.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_RHYTHM,
        READY_MOSTLY
    } ready_style_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [11:0] record_id, rest zero
    logic                  s_tuser   = 1'b0; // [0] op
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [11:0] result_id, [12] selected

    // Items waiting to be offered, and verdicts waiting to come back.
    filter_item_t pending_items[$];
    verdict_t     expected_verdicts[$];

    // The bench's own copy of the counter store and the registers. A 2-state
    // array starts at zero, which matches the store after its clearing sweep.
    int unsigned id_tally[NUM_IDS];
    int unsigned n_setting     = 1;
    logic        exact_setting = 1'b0;

    int           mismatch_count = 0;
    int           items_accepted = 0;
    int           idle_cycles    = 0;

    // Sender pacing.
    int           burst_left = 0;
    int           gap_left   = 0;
    filter_item_t next_item;

    // Receiver pacing.
    int           hold_left        = 0;
    int           long_holds_done  = 0;
    int           segment_left     = 0;
    int unsigned  ready_tick       = 0;
    ready_style_t ready_style      = READY_ALWAYS;

    n_of_m_occurrence_filter_unit #(
        .NUM_IDS   (NUM_IDS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Occurrence tally. A load raises the id's count while it is below
    // n_required + 1, so the count saturates one above the requirement. A
    // readout compares the count against the register values in force now,
    // yields one verdict and clears the count. Ids outside the store are
    // dropped by loads and always read out as not selected.
    // ------------------------------------------------------------------------
    function automatic void tally_item(input logic op, input logic [ID_W-1:0] id);
        verdict_t    v;
        int unsigned cnt;
        if (op == OP_LOAD) begin
            if (id < NUM_IDS && id_tally[id] < n_setting + 1)
                id_tally[id] = id_tally[id] + 1;
        end else begin
            v.id       = id;
            v.selected = 1'b0;
            if (id < NUM_IDS) begin
                cnt        = id_tally[id];
                v.selected = exact_setting ? (cnt == n_setting) : (cnt >= n_setting);
                id_tally[id] = 0;
            end
            expected_verdicts = {expected_verdicts, v};
        end
    endfunction

    function automatic void queue_item(input logic op, input logic [ID_W-1:0] id);
        filter_item_t it;
        it.op = op;
        it.id = id;
        pending_items = {pending_items, it};
    endfunction

    function automatic void queue_loads(input logic [ID_W-1:0] id, input int k);
        for (int i = 0; i < k; i++)
            queue_item(OP_LOAD, id);
    endfunction

    // Well-formed work for one setting: a pool of ids is drawn, then a number
    // of sets around n_required is streamed, each set holding every pool id
    // at most once, and finally every pool id is read out. Now and then a
    // stray item, a repeated id or an early readout breaks the pattern.
    function automatic void queue_set_rounds(input int unsigned n, input int budget);
        logic [ID_W-1:0] pool[$];
        logic [ID_W-1:0] base;
        int              start_size;
        int              pool_size;
        int              rounds;
        int              pick;
        start_size = pending_items.size();
        while (pending_items.size() - start_size < budget) begin
            pool.delete();
            pool_size = $urandom_range(1, 12);
            base      = ID_W'($urandom_range(0, NUM_IDS - 1));
            for (int k = 0; k < pool_size; k++) begin
                if ($urandom_range(0, 3) == 0)
                    pool = {pool, ID_W'($urandom_range(0, NUM_IDS - 1))};
                else
                    pool = {pool, base + ID_W'($urandom_range(0, 31))};
            end
            rounds = (n == 0) ? $urandom_range(0, 2) : int'(n) - 1 + $urandom_range(0, 3);
            for (int r = 0; r < rounds; r++) begin
                foreach (pool[k]) begin
                    if ($urandom_range(0, 3) != 0)
                        queue_item(OP_LOAD, pool[k]);
                end
                if ($urandom_range(0, 11) == 0) begin
                    pick = $urandom_range(0, pool_size - 1);
                    queue_item($urandom_range(0, 1) ? OP_READOUT : OP_LOAD, pool[pick]);
                end
                if ($urandom_range(0, 7) == 0)
                    queue_item($urandom_range(0, 1) ? OP_READOUT : OP_LOAD,
                               ID_W'($urandom_range(0, NUM_IDS - 1)));
            end
            for (int k = pool_size - 1; k >= 0; k--)
                queue_item(OP_READOUT, pool[k]);
        end
    endfunction

    // Two ids are driven up to the largest requirement: one gets exactly 255
    // loads, the other enough to sit at saturation, mixed with stray items
    // on other ids. The first is read out here, the second later.
    function automatic void queue_saturation_run(input logic [ID_W-1:0] id_a,
                                                 input logic [ID_W-1:0] id_b);
        logic [ID_W-1:0] stray;
        int              left_a;
        int              left_b;
        left_a = 255;
        left_b = 258;
        while (left_a + left_b > 0) begin
            if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1) == 1)) begin
                queue_item(OP_LOAD, id_a);
                left_a--;
            end else begin
                queue_item(OP_LOAD, id_b);
                left_b--;
            end
            if ($urandom_range(0, 15) == 0) begin
                stray = ID_W'($urandom_range(0, NUM_IDS - 1));
                if (stray != id_a && stray != id_b)
                    queue_item($urandom_range(0, 1) ? OP_READOUT : OP_LOAD, stray);
            end
        end
        queue_item(OP_READOUT, id_a);
    endfunction

    // Both registers are written back to back; the bench's copy follows.
    task automatic set_filter(input int unsigned n, input logic exact);
        @(posedge aclk);
        cfg_wr_en     <= 1'b1;
        cfg_addr      <= CFG_N_REQUIRED;
        cfg_wdata     <= CFG_DATA_W'(n);
        n_setting      = n;
        @(posedge aclk);
        cfg_addr      <= CFG_EXACT_MODE;
        cfg_wdata     <= CFG_DATA_W'(exact);
        exact_setting  = exact;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
    endtask

    // Waits until every item has been taken and every verdict has come back,
    // then lets a trailing load finish its update cycle.
    task automatic wait_until_idle();
        do
            @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Sender. Items leave the pending queue in bursts of random length with
    // random gaps in between; a gap of zero gives long back-to-back stretches.
    // An offered item is held until its transfer completes.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                s_tvalid <= 1'b0;
            end else begin
                next_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= S_TDATA_W'(next_item.id);
                s_tuser  <= next_item.op;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    case ($urandom_range(0, 5))
                        0, 1:    gap_left = 0;
                        5:       gap_left = $urandom_range(10, 30);
                        default: gap_left = $urandom_range(1, 6);
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It changes its pacing every segment: always ready, a coin
    // toss, a fixed rhythm, or mostly ready. Twice during the run it holds
    // off for a long stretch while the sender keeps offering, so the result
    // register fills up and the filter has to stall its input.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if ((long_holds_done == 0 && items_accepted >= 400) ||
                (long_holds_done == 1 && items_accepted >= 900)) begin
                long_holds_done++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (segment_left == 0) begin
                    ready_style  = ready_style_t'($urandom_range(0, 3));
                    segment_left = $urandom_range(16, 160);
                end
                segment_left--;
                ready_tick++;
                case (ready_style)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    READY_RHYTHM: m_tready <= (ready_tick % 7) < 3;
                    default:      m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checking. A result transfer is compared with the oldest outstanding
    // verdict before the input transfer of the same edge is tallied, so the
    // order within the time step never matters.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result, id %0d selected %0b",
                                 $time, m_tdata[ID_W-1:0], m_tdata[ID_W]);
                end else begin
                    if (m_tdata[ID_W-1:0] !== expected_verdicts[0].id ||
                        m_tdata[ID_W] !== expected_verdicts[0].selected) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: mismatch, expected id %0d sel %0b, got id %0d sel %0b",
                                     $time, expected_verdicts[0].id,
                                     expected_verdicts[0].selected,
                                     m_tdata[ID_W-1:0], m_tdata[ID_W]);
                    end
                    void'(expected_verdicts.pop_front());
                end
            end
            if (s_tvalid && s_tready) begin
                tally_item(s_tuser, s_tdata[ID_W-1:0]);
                items_accepted <= items_accepted + 1;
            end
        end
    end

    // Watchdog: too long without any transfer on either side ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. Short directed phases first, each under its own register
    // setting, then random phases across small and extreme requirements.
    // Registers change only once the filter has gone quiet.
    // ------------------------------------------------------------------------
    initial begin
        logic [ID_W-1:0] sat_a;
        logic [ID_W-1:0] sat_b;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Exact mode, two sets: exactly two, too many (saturated at three),
        // never seen, and a count left behind for the next phase.
        set_filter(2, 1'b1);
        @(negedge aclk);
        queue_loads(12'd0, 2);
        queue_item(OP_READOUT, 12'd0);
        queue_loads(12'd4095, 3);
        queue_item(OP_READOUT, 12'd4095);
        queue_item(OP_READOUT, 12'd7);
        queue_loads(12'd9, 4);
        wait_until_idle();

        // Raising the requirement mid-stream: the saturated count of id 9
        // keeps its value and climbs on to the new requirement.
        set_filter(4, 1'b1);
        @(negedge aclk);
        queue_item(OP_LOAD, 12'd9);
        queue_item(OP_READOUT, 12'd9);
        queue_item(OP_LOAD, 12'hAAA);
        queue_item(OP_READOUT, 12'hAAA);
        wait_until_idle();

        // A requirement of zero: threshold mode takes every id, counts stop
        // at one.
        set_filter(0, 1'b0);
        @(negedge aclk);
        queue_loads(12'h555, 2);
        queue_item(OP_READOUT, 12'h555);
        queue_item(OP_READOUT, 12'd100);
        wait_until_idle();

        // Zero in exact mode only takes ids that were never loaded.
        set_filter(0, 1'b1);
        @(negedge aclk);
        queue_item(OP_LOAD, 12'h555);
        queue_item(OP_READOUT, 12'h555);
        queue_item(OP_READOUT, 12'd100);
        wait_until_idle();

        // Random phases over a spread of settings.
        set_filter(1, 1'b0);
        @(negedge aclk);
        queue_set_rounds(1, 160);
        wait_until_idle();

        set_filter(3, 1'b1);
        @(negedge aclk);
        queue_set_rounds(3, 180);
        wait_until_idle();

        set_filter(2, 1'b0);
        @(negedge aclk);
        queue_set_rounds(2, 160);
        wait_until_idle();

        set_filter(5, 1'b1);
        @(negedge aclk);
        queue_set_rounds(5, 150);
        wait_until_idle();

        set_filter(0, 1'b1);
        @(negedge aclk);
        queue_set_rounds(0, 60);
        wait_until_idle();

        set_filter(1, 1'b1);
        @(negedge aclk);
        queue_set_rounds(1, 120);
        wait_until_idle();

        set_filter(6, 1'b0);
        @(negedge aclk);
        queue_set_rounds(6, 100);
        wait_until_idle();

        // The largest requirement, first in exact mode, then the saturated id
        // is judged under threshold mode.
        sat_a = ID_W'($urandom_range(0, NUM_IDS - 1));
        sat_b = sat_a ^ ID_W'($urandom_range(1, NUM_IDS - 1));
        set_filter(255, 1'b1);
        @(negedge aclk);
        queue_saturation_run(sat_a, sat_b);
        wait_until_idle();

        set_filter(255, 1'b0);
        @(negedge aclk);
        queue_item(OP_READOUT, sat_b);
        queue_item(OP_READOUT, sat_a);
        wait_until_idle();

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/nofm_pkg.sv
hw/rtl/nofm_ram.sv
hw/rtl/nofm_datapath.sv
hw/rtl/nofm_ctrl.sv
hw/rtl/n_of_m_occurrence_filter_unit.sv
bench/tb_n_of_m_occurrence_filter_unit.sv
